// ===== sv/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, operation codes and structs of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   // built size of the bitmap and its word organization
   localparam int NUM_BLOCKS = 256;
   localparam int WORD_W     = 16;
   localparam int NUM_WORDS  = NUM_BLOCKS / WORD_W;
   localparam int WADDR_W    = $clog2(NUM_WORDS);
   localparam int IDX_W      = $clog2(WORD_W);
   localparam int FREE_W     = $clog2(WORD_W) + 1;

   // widths fixed by the item fields
   localparam int OP_W    = 3;
   localparam int BLK_W   = 9;
   localparam int FOUND_W = 8;

   typedef enum logic [OP_W-1:0] {
      OP_SEARCH = 3'd0,
      OP_MARK   = 3'd1,
      OP_CLEAR  = 3'd2,
      OP_CHECK  = 3'd3,
      OP_TOTAL  = 3'd4
   } op_type;

   // one request item, operation in the lowest bits
   typedef struct packed {
      logic [BLK_W-1:0]        run_length;
      logic [BLK_W-1:0]        end_block;
      logic signed [BLK_W-1:0] first_block;
      logic [OP_W-1:0]         operation;
   } item_type;

   // word evaluation inputs
   typedef struct packed {
      item_type            item;
      logic [BLK_W-1:0]    act;
      logic [WADDR_W-1:0]  word_idx;
      logic [WORD_W-1:0]   data;
      logic [BLK_W-1:0]    run_carry;
   } eval_in_type;

   // word evaluation results
   typedef struct packed {
      logic [WORD_W-1:0]   word_next;
      logic                hit;
      logic [BLK_W-1:0]    hit_start;
      logic [BLK_W-1:0]    run_next;
      logic [FREE_W-1:0]   free_cnt;
      logic                check_bad;
   } eval_out_type;

endpackage

// ===== sv/bba_word_eval.sv =====
// ----------------------------------------------------------------------------
// bba_word_eval
// Evaluates one bitmap word: range update, free run tracking, free count and
// range check, all in parallel over the bits of the word.
// ----------------------------------------------------------------------------
module bba_word_eval (
   input  bba_pkg::eval_in_type  ev_in,
   output bba_pkg::eval_out_type ev_out
);
   import bba_pkg::*;

   logic [BLK_W-1:0] g_arr    [WORD_W];
   logic [BLK_W-1:0] run_arr  [WORD_W];
   logic [IDX_W-1:0] last_arr [WORD_W];
   logic             any_arr  [WORD_W];
   logic [WORD_W-1:0] blocked;
   logic [WORD_W-1:0] range_v;
   logic [WORD_W-1:0] chk_v;
   logic [WORD_W-1:0] hit_v;
   logic             first_neg;
   logic [BLK_W-1:0] first_u;

   assign first_neg = ev_in.item.first_block[BLK_W-1];
   assign first_u   = $unsigned(ev_in.item.first_block);

   // per bit block number, blocking, range membership
   always_comb begin
      for (int j = 0; j < WORD_W; j++) begin
         g_arr[j]   = BLK_W'({ev_in.word_idx, IDX_W'(j)});
         blocked[j] = ev_in.data[j] || !(g_arr[j] < ev_in.act);
         range_v[j] = (first_neg || (g_arr[j] >= first_u))
                      && (g_arr[j] < ev_in.item.end_block)
                      && (g_arr[j] < ev_in.act);
         chk_v[j]   = !first_neg && (g_arr[j] >= first_u)
                      && (g_arr[j] < ev_in.item.end_block) && ev_in.data[j];
      end
   end

   // highest blocked bit at or below each position
   always_comb begin
      for (int j = 0; j < WORD_W; j++) begin
         any_arr[j]  = 1'b0;
         last_arr[j] = '0;
         for (int i = 0; i <= j; i++) begin
            if (blocked[i]) begin
               any_arr[j]  = 1'b1;
               last_arr[j] = IDX_W'(i);
            end
         end
      end
   end

   // free run ending at each bit and whether it reaches the length
   always_comb begin
      for (int j = 0; j < WORD_W; j++) begin
         run_arr[j] = any_arr[j] ? (BLK_W'(j) - BLK_W'(last_arr[j]))
                                 : (ev_in.run_carry + BLK_W'(j) + BLK_W'(1));
         hit_v[j]   = (ev_in.item.run_length != '0)
                      && (run_arr[j] >= ev_in.item.run_length);
      end
   end

   always_comb begin
      ev_out.hit       = 1'b0;
      ev_out.hit_start = '0;
      for (int j = WORD_W - 1; j >= 0; j--) begin
         if (hit_v[j]) begin
            ev_out.hit       = 1'b1;
            ev_out.hit_start = g_arr[j] + BLK_W'(1) - ev_in.item.run_length;
         end
      end
   end

   // updated word for mark and clear
   always_comb begin
      case (ev_in.item.operation)
         OP_MARK:  ev_out.word_next = ev_in.data | range_v;
         OP_CLEAR: ev_out.word_next = ev_in.data & ~range_v;
         default:  ev_out.word_next = ev_in.data;
      endcase
   end

   assign ev_out.run_next  = run_arr[WORD_W-1];
   assign ev_out.free_cnt  = FREE_W'($countones(~blocked));
   assign ev_out.check_bad = |chk_v;

endmodule

// ===== sv/bitmap_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// First fit contiguous block allocator over a used/free bitmap held in a
// word wide synchronous memory, with mark, clear, range check and free total.
// ----------------------------------------------------------------------------
//  channel   dir  handshake             payload
//  req_*     in   tvalid/tready         operation, first_block, end_block,
//                                       run_length
//  rsp_*     out  tvalid/tready         success, found_block
//  csr_*     in   wr_en                 active_blocks
//
//  every item sweeps all NUM_WORDS bitmap words, one memory read per cycle;
//  the result is loaded into the output register once the last word is
//  processed, and the next item is taken only after that load, so items
//  never overlap; every word goes through the single read port.
//  reset clears a per-word valid flag; an unwritten word reads as all free.
//  a result waits in the output register; a new item is taken meanwhile, and
//  the following result stalls only while that register is still full.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // operation[2:0], first_block[11:3], end_block[20:12], run_length[29:21]
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // success[0], found_block[8:1]
   output logic [15:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [bba_pkg::BLK_W-1:0] csr_wr_data
);
   import bba_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   item_type           item_ff, item_in;
   logic [BLK_W-1:0]   active_blocks_ff;
   logic [WADDR_W-1:0] cnt_ff, cnt_in;
   logic               proc_vld_ff, proc_vld_in;
   logic [WADDR_W-1:0] proc_word_ff;
   logic [WORD_W-1:0]  rd_data_ff;
   logic [WORD_W-1:0]  used_mem_ff [NUM_WORDS];
   logic [NUM_WORDS-1:0] valid_ff;
   logic               hit_ff, hit_in;
   logic [FOUND_W-1:0] found_ff, found_in;
   logic [BLK_W-1:0]   run_ff, run_in;
   logic [BLK_W-1:0]   free_ff, free_in;
   logic               bad_ff, bad_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [FOUND_W-1:0] rsp_found_ff, rsp_found_in;

   logic               accept;
   logic               rd_en;
   logic               wr_en;
   logic               load;
   logic [BLK_W-1:0]   act;
   logic [BLK_W-1:0]   first_u;
   eval_in_type        ev_in;
   eval_out_type       ev_out;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rd_en      = (state_ff == ST_SCAN);
   assign wr_en      = proc_vld_ff && ((item_ff.operation == OP_MARK)
                                       || (item_ff.operation == OP_CLEAR));
   assign load       = (state_ff == ST_DONE) && !proc_vld_ff
                       && (!rsp_tvalid_ff || rsp_tready);
   assign act        = (active_blocks_ff > BLK_W'(NUM_BLOCKS)) ?
                       BLK_W'(NUM_BLOCKS) : active_blocks_ff;
   assign first_u    = $unsigned(item_ff.first_block);

   // word evaluation on the registered read data
   assign ev_in.item      = item_ff;
   assign ev_in.act       = act;
   assign ev_in.word_idx  = proc_word_ff;
   assign ev_in.data      = valid_ff[proc_word_ff] ? rd_data_ff : '0;
   assign ev_in.run_carry = run_ff;

   bba_word_eval u_eval (
      .ev_in  (ev_in),
      .ev_out (ev_out)
   );

   // sequencing, accumulation and result formation
   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      cnt_in        = cnt_ff;
      proc_vld_in   = rd_en;
      hit_in        = hit_ff;
      found_in      = found_ff;
      run_in        = run_ff;
      free_in       = free_ff;
      bad_in        = bad_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_ok_in     = rsp_ok_ff;
      rsp_found_in  = rsp_found_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in  = req_tdata[$bits(item_type)-1:0];
               cnt_in   = '0;
               hit_in   = 1'b0;
               found_in = '0;
               run_in   = '0;
               free_in  = '0;
               bad_in   = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + WADDR_W'(1);
            if (cnt_ff == WADDR_W'(NUM_WORDS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // fold one processed word into the running totals
      if (proc_vld_ff) begin
         if (!hit_ff && ev_out.hit) begin
            hit_in   = 1'b1;
            found_in = ev_out.hit_start[FOUND_W-1:0];
         end
         run_in  = ev_out.run_next;
         free_in = free_ff + BLK_W'(ev_out.free_cnt);
         bad_in  = bad_ff || ev_out.check_bad;
      end

      // final result per operation
      if (load) begin
         rsp_tvalid_in = 1'b1;
         rsp_found_in  = '0;
         case (item_ff.operation)
            OP_SEARCH: begin
               rsp_ok_in    = hit_ff;
               rsp_found_in = hit_ff ? found_ff : '0;
            end
            OP_MARK:   rsp_ok_in = 1'b1;
            OP_CLEAR:  rsp_ok_in = 1'b1;
            OP_CHECK:  rsp_ok_in = !item_ff.first_block[BLK_W-1] && !bad_ff
                                   && !((first_u < item_ff.end_block)
                                        && (item_ff.end_block > act));
            OP_TOTAL:  rsp_ok_in = (free_ff >= item_ff.run_length);
            default:   rsp_ok_in = 1'b0;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         proc_vld_ff      <= 1'b0;
         rsp_tvalid_ff    <= 1'b0;
         valid_ff         <= '0;
         active_blocks_ff <= BLK_W'(NUM_BLOCKS);
      end else begin
         state_ff      <= state_in;
         proc_vld_ff   <= proc_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (wr_en) begin
            valid_ff[proc_word_ff] <= 1'b1;
         end
         if (csr_wr_en) begin
            active_blocks_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      cnt_ff       <= cnt_in;
      proc_word_ff <= cnt_ff;
      hit_ff       <= hit_in;
      found_ff     <= found_in;
      run_ff       <= run_in;
      free_ff      <= free_in;
      bad_ff       <= bad_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_found_ff <= rsp_found_in;
   end

   // bitmap memory, each word read and written back while the next word is read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         used_mem_ff[proc_word_ff] <= ev_out.word_next;
      end
      if (rd_en) begin
         rd_data_ff <= used_mem_ff[cnt_ff];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'd0, rsp_found_ff, rsp_ok_ff};

   // checks
   a_proc_not_idle: assert property (@(posedge clock) disable iff (reset)
      proc_vld_ff |-> (state_ff != ST_IDLE))
      else $error("word processed while idle");

   a_scan_feeds_proc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> proc_vld_ff)
      else $error("memory read not followed by processing");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> ((state_ff == ST_SCAN) && (cnt_ff == '0)))
      else $error("accepted item did not start a sweep at word zero");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result shown without a finished sweep");

endmodule
